// File: src/midi_note_message_parser_defines.svh
// assertion macros used by the parser back end
`ifndef MIDI_NOTE_MESSAGE_PARSER_DEFINES_SVH
`define MIDI_NOTE_MESSAGE_PARSER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MNMP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mnmp check failed");

// next-cycle implication, checked out of reset
`define MNMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mnmp check failed");

`endif

// File: src/mnmp_pkg.sv
`timescale 1ns / 1ps
package mnmp_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_OWN_CHANNEL = 3'd0;

  typedef enum logic [2:0] {
    EV_NOTE_ON  = 3'd0,
    EV_NOTE_OFF = 3'd1,
    EV_CLOCK    = 3'd2,
    EV_START    = 3'd3,
    EV_STOP     = 3'd4,
    EV_CONTINUE = 3'd5
  } event_kind_t;

  localparam logic [7:0] BYTE_CLOCK    = 8'hF8;
  localparam logic [7:0] BYTE_START    = 8'hFA;
  localparam logic [7:0] BYTE_CONTINUE = 8'hFB;
  localparam logic [7:0] BYTE_STOP     = 8'hFC;

  localparam logic [3:0] TYPE_NOTE_ON  = 4'h9;
  localparam logic [3:0] TYPE_NOTE_OFF = 4'h8;
  localparam logic [3:0] CHANNEL_ALL   = 4'h0;

  typedef enum logic [1:0] {
    CLS_SYNC   = 2'd0,
    CLS_STATUS = 2'd1,
    CLS_DATA   = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t        cls;
    event_kind_t ev;
    logic        match;
    logic [7:0]  rx_byte;
  } entry_t;

endpackage

// File: src/mnmp_front.sv
`timescale 1ns / 1ps
module mnmp_front (
  input  logic             push,
  input  logic [7:0]       in_rx_byte,
  input  logic [3:0]       own_channel,
  input  logic             q_full,
  output logic             q_wr,
  output mnmp_pkg::entry_t q_din
);

  always_comb begin
    q_din.rx_byte = in_rx_byte;
    q_din.match   = (in_rx_byte[3:0] == own_channel) || (own_channel == mnmp_pkg::CHANNEL_ALL);
    q_din.ev      = mnmp_pkg::EV_CLOCK;
    case (in_rx_byte)
      mnmp_pkg::BYTE_CLOCK: begin
        q_din.cls = mnmp_pkg::CLS_SYNC;
        q_din.ev  = mnmp_pkg::EV_CLOCK;
      end
      mnmp_pkg::BYTE_START: begin
        q_din.cls = mnmp_pkg::CLS_SYNC;
        q_din.ev  = mnmp_pkg::EV_START;
      end
      mnmp_pkg::BYTE_CONTINUE: begin
        q_din.cls = mnmp_pkg::CLS_SYNC;
        q_din.ev  = mnmp_pkg::EV_CONTINUE;
      end
      mnmp_pkg::BYTE_STOP: begin
        q_din.cls = mnmp_pkg::CLS_SYNC;
        q_din.ev  = mnmp_pkg::EV_STOP;
      end
      default: begin
        q_din.cls = in_rx_byte[7] ? mnmp_pkg::CLS_STATUS : mnmp_pkg::CLS_DATA;
      end
    endcase
  end

  assign q_wr = push && !q_full;

endmodule

// File: src/mnmp_fifo.sv
`timescale 1ns / 1ps
module mnmp_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  mnmp_pkg::entry_t din,
  input  logic             rd_en,
  output mnmp_pkg::entry_t dout,
  output logic             full,
  output logic             empty
);

  localparam int unsigned AW = mnmp_pkg::FIFO_AW;

  mnmp_pkg::entry_t mem_r [mnmp_pkg::FIFO_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_wr, do_rd;

  assign full  = (count_r == (AW+1)'(mnmp_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// File: src/mnmp_back.sv
`timescale 1ns / 1ps
`include "midi_note_message_parser_defines.svh"
module mnmp_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  mnmp_pkg::entry_t q_dout,
  output logic             q_rd,
  input  logic             pop,
  output logic             empty,
  output logic [2:0]       out_event_kind,
  output logic [3:0]       out_channel,
  output logic [6:0]       out_key,
  output logic [6:0]       out_velocity
);

  logic [7:0] status_r, status_nxt;
  logic       addressed_r, addressed_nxt;
  logic       parity_r, parity_nxt;
  logic [6:0] key_r, key_nxt;

  logic                  out_valid_r, out_valid_nxt;
  mnmp_pkg::event_kind_t out_kind_r, res_kind;
  logic [3:0]            out_chan_r, res_chan;
  logic [6:0]            out_key_r, res_key;
  logic [6:0]            out_vel_r, res_vel;
  logic                  res_valid;
  logic                  take;

  // consume one entry whenever the output slot is free or being drained
  assign take = !q_empty && (!out_valid_r || pop);
  assign q_rd = take;

  always_comb begin
    status_nxt    = status_r;
    addressed_nxt = addressed_r;
    parity_nxt    = parity_r;
    key_nxt       = key_r;
    res_valid     = 1'b0;
    res_kind      = q_dout.ev;
    res_chan      = '0;
    res_key       = '0;
    res_vel       = '0;
    case (q_dout.cls)
      mnmp_pkg::CLS_SYNC: begin
        res_valid = 1'b1;
      end
      mnmp_pkg::CLS_STATUS: begin
        status_nxt    = q_dout.rx_byte;
        addressed_nxt = q_dout.match;
        parity_nxt    = 1'b0;
        key_nxt       = '0;
      end
      mnmp_pkg::CLS_DATA: begin
        if (addressed_r) begin
          if (!parity_r) begin
            key_nxt    = q_dout.rx_byte[6:0];
            parity_nxt = 1'b1;
          end else begin
            parity_nxt = 1'b0;
            res_chan   = status_r[3:0];
            res_key    = key_r;
            res_vel    = q_dout.rx_byte[6:0];
            if (status_r[7:4] == mnmp_pkg::TYPE_NOTE_ON) begin
              res_valid = 1'b1;
              res_kind  = mnmp_pkg::EV_NOTE_ON;
            end else if (status_r[7:4] == mnmp_pkg::TYPE_NOTE_OFF) begin
              res_valid = 1'b1;
              res_kind  = mnmp_pkg::EV_NOTE_OFF;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = res_valid;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r    <= '0;
      addressed_r <= 1'b0;
      parity_r    <= 1'b0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        status_r    <= status_nxt;
        addressed_r <= addressed_nxt;
        parity_r    <= parity_nxt;
        key_r       <= key_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_kind_r <= res_kind;
      out_chan_r <= res_chan;
      out_key_r  <= res_key;
      out_vel_r  <= res_vel;
    end
  end

  assign empty          = !out_valid_r;
  assign out_event_kind = 3'(out_kind_r);
  assign out_channel    = out_chan_r;
  assign out_key        = out_key_r;
  assign out_velocity   = out_vel_r;

  `MNMP_ASSERT_NOW(a_no_overwrite, out_valid_r && !pop, !take)
  `MNMP_ASSERT_NEXT(a_sync_emits, take && q_dout.cls == mnmp_pkg::CLS_SYNC,
    out_valid_r && out_kind_r != mnmp_pkg::EV_NOTE_ON && out_kind_r != mnmp_pkg::EV_NOTE_OFF)
  `MNMP_ASSERT_NEXT(a_status_clears, take && q_dout.cls == mnmp_pkg::CLS_STATUS,
    !parity_r && key_r == '0)
  `MNMP_ASSERT_NEXT(a_unaddr_hold, take && q_dout.cls == mnmp_pkg::CLS_DATA && !addressed_r,
    $stable(parity_r) && $stable(key_r) && !out_valid_r)

endmodule

// File: src/midi_note_message_parser.sv
`timescale 1ns / 1ps
// each item enters the queue, then the back end puts its result (if any) in the output register
// throughput: one item per cycle in and out unless full or not popped; a 4-deep item queue decouples push from pop
// the back end takes a queued item whenever its single output register is free or popped
// reset (rst_n low, synchronous): queue, parser state and output flag cleared, own_channel 0
module midi_note_message_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  // result channel
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_key,
  output logic [6:0]  out_velocity,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [mnmp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configured channel; the user must write it only while the parser is idle, the block does not enforce this
  logic [3:0] own_channel_r;
  logic       cfg_wr;

  // front to queue
  logic             q_wr;
  mnmp_pkg::entry_t q_din;
  // queue to back
  logic             q_rd;
  logic             q_empty;
  mnmp_pkg::entry_t q_dout;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_channel_r <= '0;
    end else if (cfg_wr && paddr == mnmp_pkg::ADDR_OWN_CHANNEL) begin
      own_channel_r <= pwdata[3:0];
    end
  end

  // read back the one register, zero elsewhere
  assign prdata = (paddr == mnmp_pkg::ADDR_OWN_CHANNEL) ? {28'd0, own_channel_r} : 32'd0;

  // classify each byte: sync event, status or data, plus channel match
  mnmp_front u_front (
    .push        (push),
    .in_rx_byte  (in_rx_byte),
    .own_channel (own_channel_r),
    .q_full      (full),
    .q_wr        (q_wr),
    .q_din       (q_din)
  );

  // short item queue between the two halves
  mnmp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (q_wr),
    .din   (q_din),
    .rd_en (q_rd),
    .dout  (q_dout),
    .full  (full),
    .empty (q_empty)
  );

  // running-status parser and output register
  mnmp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_dout         (q_dout),
    .q_rd           (q_rd),
    .pop            (pop),
    .empty          (empty),
    .out_event_kind (out_event_kind),
    .out_channel    (out_channel),
    .out_key        (out_key),
    .out_velocity   (out_velocity)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int ITEM_TARGET  = 1700;
  localparam int PHASES       = 8;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 300;
  localparam int MAX_REPORTS  = 50;

  // message codes used by the stimulus beyond the note and sync codes
  localparam logic [3:0] MSG_CONTROL   = 4'hB;
  localparam logic [7:0] SYS_EXCLUSIVE = 8'hF0;
  localparam logic [7:0] SYS_RESET     = 8'hFF;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        pop = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [mnmp_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = 32'd0;
  wire         full;
  wire         empty;
  wire  [2:0]  out_event_kind;
  wire  [3:0]  out_channel;
  wire  [6:0]  out_key;
  wire  [6:0]  out_velocity;
  wire  [31:0] prdata;
  wire         pready;

  always #5 clk = ~clk;

  midi_note_message_parser DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_rx_byte     (in_rx_byte),
    .empty          (empty),
    .pop            (pop),
    .out_event_kind (out_event_kind),
    .out_channel    (out_channel),
    .out_key        (out_key),
    .out_velocity   (out_velocity),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  typedef struct {
    mnmp_pkg::event_kind_t kind;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
  } midi_event_t;

  midi_event_t pending_events [$];
  midi_event_t oldest_event;

  // parser state as the block should hold it
  logic [3:0] own_chan = mnmp_pkg::CHANNEL_ALL;
  logic [7:0] cur_status = 8'h00;
  logic       listening = 1'b0;
  logic       have_key = 1'b0;
  logic [6:0] held_key = 7'h00;

  int  fail_count = 0;
  int  sent_bytes = 0;
  int  cycle_count = 0;
  int  hold_requests = 0;
  int  holds_served = 0;
  int  pop_hold = 0;
  int  pop_gap = 0;
  bit  steady = 1'b0;

  task automatic queue_event(input mnmp_pkg::event_kind_t kind, input logic [3:0] ch,
                             input logic [6:0] k, input logic [6:0] v);
    midi_event_t ev;
    ev.kind = kind;
    ev.channel = ch;
    ev.key = k;
    ev.velocity = v;
    pending_events.push_back(ev);
  endtask

  // advance the expected parser state by one accepted byte
  task automatic parse_midi_byte(input logic [7:0] b);
    case (b)
      mnmp_pkg::BYTE_CLOCK:    queue_event(mnmp_pkg::EV_CLOCK, 4'h0, 7'h00, 7'h00);
      mnmp_pkg::BYTE_START:    queue_event(mnmp_pkg::EV_START, 4'h0, 7'h00, 7'h00);
      mnmp_pkg::BYTE_CONTINUE: queue_event(mnmp_pkg::EV_CONTINUE, 4'h0, 7'h00, 7'h00);
      mnmp_pkg::BYTE_STOP:     queue_event(mnmp_pkg::EV_STOP, 4'h0, 7'h00, 7'h00);
      default: begin
        if (b[7]) begin
          // any other status byte restarts the message
          cur_status = b;
          have_key = 1'b0;
          held_key = 7'h00;
          listening = (b[3:0] == own_chan) || (own_chan == mnmp_pkg::CHANNEL_ALL);
        end else if (!listening) begin
        end else if (!have_key) begin
          held_key = b[6:0];
          have_key = 1'b1;
        end else begin
          have_key = 1'b0;
          if (cur_status[7:4] == mnmp_pkg::TYPE_NOTE_ON)
            queue_event(mnmp_pkg::EV_NOTE_ON, cur_status[3:0], held_key, b[6:0]);
          else if (cur_status[7:4] == mnmp_pkg::TYPE_NOTE_OFF)
            queue_event(mnmp_pkg::EV_NOTE_OFF, cur_status[3:0], held_key, b[6:0]);
        end
      end
    endcase
  endtask

  // mostly back to back, some short pauses, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sync();
    case ($urandom_range(0, 3))
      0: return mnmp_pkg::BYTE_CLOCK;
      1: return mnmp_pkg::BYTE_START;
      2: return mnmp_pkg::BYTE_CONTINUE;
      default: return mnmp_pkg::BYTE_STOP;
    endcase
  endfunction

  // system and real-time status bytes that are not sync events
  function automatic logic [7:0] pick_system_status();
    int r;
    r = $urandom_range(0, 11);
    if (r < 8) return SYS_EXCLUSIVE + 8'(r);
    if (r == 8) return 8'hF9;
    if (r == 9) return 8'hFD;
    if (r == 10) return 8'hFE;
    return SYS_RESET;
  endfunction

  function automatic logic [7:0] pick_data();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'h7F;
    return 8'($urandom_range(0, 127));
  endfunction

  // offer one item after a random pause; push stays high on return
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (full);
    parse_midi_byte(b);
    sent_bytes++;
  endtask

  task automatic send_note_message(input logic [3:0] mtype, input logic [3:0] ch,
                                   input int pairs, input bit broken);
    send_byte({mtype, ch});
    for (int i = 0; i < pairs; i++) begin
      send_byte(pick_data());
      // real-time bytes may fall between the two data bytes
      if ($urandom_range(0, 19) == 0) send_byte(pick_sync());
      send_byte(pick_data());
    end
    if (broken) send_byte(pick_data());
  endtask

  // stop offering and let every result and any trailing item drain
  task automatic settle_idle();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_own_channel(input logic [3:0] ch);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= mnmp_pkg::ADDR_OWN_CHANNEL;
    pwdata <= {28'd0, ch};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    own_chan = ch;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // field extremes, every event kind and the corner cases of the parser
  task automatic test_directed_bytes();
    logic [7:0] seq [26];
    seq = '{8'h40,
            mnmp_pkg::BYTE_CLOCK, mnmp_pkg::BYTE_START, mnmp_pkg::BYTE_CONTINUE,
            mnmp_pkg::BYTE_STOP,
            {mnmp_pkg::TYPE_NOTE_ON, 4'h0}, 8'h00, 8'h7F,
            8'h7F, 8'h00,
            {mnmp_pkg::TYPE_NOTE_OFF, 4'hF}, 8'h3C, mnmp_pkg::BYTE_CLOCK, 8'h40,
            {MSG_CONTROL, 4'h5}, 8'h07, 8'h64,
            SYS_EXCLUSIVE, 8'h11, 8'h22, SYS_RESET,
            {mnmp_pkg::TYPE_NOTE_ON, 4'hA}, 8'h55, {mnmp_pkg::TYPE_NOTE_ON, 4'h3},
            8'h01, 8'h02};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_channel_filter();
    settle_idle();
    set_own_channel(4'hF);
    send_note_message(mnmp_pkg::TYPE_NOTE_ON, 4'hF, 2, 1'b0);
    send_note_message(mnmp_pkg::TYPE_NOTE_ON, 4'h0, 2, 1'b0);
    send_note_message(mnmp_pkg::TYPE_NOTE_OFF, 4'h3, 1, 1'b0);
    send_note_message(mnmp_pkg::TYPE_NOTE_OFF, 4'hF, 1, 1'b0);
    settle_idle();
    set_own_channel(4'h1);
    send_note_message(mnmp_pkg::TYPE_NOTE_ON, 4'h1, 1, 1'b0);
    send_note_message(mnmp_pkg::TYPE_NOTE_ON, 4'h0, 1, 1'b0);
    send_note_message(mnmp_pkg::TYPE_NOTE_OFF, 4'h1, 1, 1'b0);
  endtask

  // well-formed note traffic with random content, plus noise and cut messages
  task automatic test_random_stream();
    int r;
    int stop_at;
    logic [3:0] mtype;
    logic [3:0] ch;
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      if (p == 0) set_own_channel(mnmp_pkg::CHANNEL_ALL);
      else if (p == 1) set_own_channel(4'hF);
      else set_own_channel(4'($urandom_range(0, 15)));
      stop_at = sent_bytes + ITEM_TARGET / PHASES;
      while (sent_bytes < stop_at) begin
        steady <= ($urandom_range(0, 4) == 0);
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if ($urandom_range(0, 4) != 0)
            mtype = $urandom_range(0, 1) ? mnmp_pkg::TYPE_NOTE_ON : mnmp_pkg::TYPE_NOTE_OFF;
          else
            mtype = 4'($urandom_range(4'hA, 4'hE));
          if (own_chan != mnmp_pkg::CHANNEL_ALL && $urandom_range(0, 3) != 0)
            ch = own_chan;
          else
            ch = 4'($urandom_range(0, 15));
          send_note_message(mtype, ch, $urandom_range(1, 4), $urandom_range(0, 9) == 0);
        end else if (r < 82) begin
          send_byte(pick_sync());
        end else if (r < 90) begin
          send_byte(pick_system_status());
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_backpressure();
    settle_idle();
    steady <= 1'b1;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 6; i++) begin
      send_byte(pick_sync());
      send_note_message(mnmp_pkg::TYPE_NOTE_ON, own_chan, 3, 1'b0);
    end
    settle_idle();
    steady <= 1'b0;
  endtask

  // receiver side: random pops, and a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      pop_hold <= LONG_HOLD;
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold <= pop_hold - 1;
      pop <= 1'b0;
    end else if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      pop_gap <= pick_gap();
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // each popped result against the oldest expected event
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   out_event_kind);
      end else begin
        oldest_event = pending_events.pop_front();
        check_field("event_kind", oldest_event.kind, out_event_kind);
        check_field("channel", oldest_event.channel, out_channel);
        check_field("key", oldest_event.key, out_key);
        check_field("velocity", oldest_event.velocity, out_velocity);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_bytes();
    test_channel_filter();
    test_random_stream();
    test_backpressure();
    settle_idle();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
